>>> rtl/sbba_pkg.sv
// ----------------------------------------------------------------------------
// sbba_pkg
// Shared types and constants of the scaled bitmap blitter front end.
// ----------------------------------------------------------------------------
`default_nettype none

package sbba_pkg;

  localparam int unsigned FB_WIDTH   = 1024;
  localparam int unsigned FB_HEIGHT  = 768;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DST_W      = 12;
  localparam int unsigned SRC_W      = 13;
  localparam int unsigned SPAN_W     = 12;
  localparam int unsigned EDGE_W     = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // scaled offset: (2*span*pos + dspan) / (2*dspan)
  localparam int unsigned PROD_W     = SPAN_W + SRC_W;   // span * pos
  localparam int unsigned NUM_W      = PROD_W + 1;       // doubled plus dspan
  localparam int unsigned DEN_W      = SPAN_W + 1;       // 2 * dspan
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int unsigned ALPHA_LSB  = 24;
  localparam logic [7:0]  ALPHA_THRESH = 8'd128;

  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_NEXT  = 2'd1,
    CMD_COLOR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_LEFT   = 3'd0,
    REG_DEST_TOP    = 3'd1,
    REG_DEST_SPAN_X = 3'd2,
    REG_DEST_SPAN_Y = 3'd3,
    REG_SRC_LEFT    = 3'd4,
    REG_SRC_TOP     = 3'd5,
    REG_SRC_SPAN_X  = 3'd6,
    REG_SRC_SPAN_Y  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [EDGE_W-1:0] dest_left;
    logic [EDGE_W-1:0] dest_top;
    logic [SPAN_W-1:0] dest_span_x;
    logic [SPAN_W-1:0] dest_span_y;
    logic [SPAN_W-1:0] src_left;
    logic [SPAN_W-1:0] src_top;
    logic [SPAN_W-1:0] src_span_x;
    logic [SPAN_W-1:0] src_span_y;
  } cfg_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [WORD_W-1:0] word;
  } q_head_t;

  typedef struct packed {
    logic [DST_W-1:0]  out_dst_x;
    logic [DST_W-1:0]  out_dst_y;
    logic [SRC_W-1:0]  out_src_x;
    logic [SRC_W-1:0]  out_src_y;
    logic              write_enable;
    logic [WORD_W-1:0] out_word;
    logic              last_pixel;
    logic              none_left;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/sbba_channels.sv
// ----------------------------------------------------------------------------
// sbba channels
// Valid/ready channel interfaces for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbba_in_if;
  logic                            valid;
  logic                            ready;
  logic [sbba_pkg::CMD_W-1:0]      command;
  logic [sbba_pkg::WORD_W-1:0]     pixel_word;

  modport source (output valid, output command, output pixel_word, input ready);
  modport sink   (input valid, input command, input pixel_word, output ready);
endinterface

interface sbba_out_if;
  logic                            valid;
  logic                            ready;
  logic [sbba_pkg::DST_W-1:0]      out_dst_x;
  logic [sbba_pkg::DST_W-1:0]      out_dst_y;
  logic [sbba_pkg::SRC_W-1:0]      out_src_x;
  logic [sbba_pkg::SRC_W-1:0]      out_src_y;
  logic                            write_enable;
  logic [sbba_pkg::WORD_W-1:0]     out_word;
  logic                            last_pixel;
  logic                            none_left;

  modport source (output valid, output out_dst_x, output out_dst_y, output out_src_x,
                  output out_src_y, output write_enable, output out_word,
                  output last_pixel, output none_left, input ready);
  modport sink   (input valid, input out_dst_x, input out_dst_y, input out_src_x,
                  input out_src_y, input write_enable, input out_word,
                  input last_pixel, input none_left, output ready);
endinterface

`default_nettype wire

>>> rtl/scaled_bitmap_blit_alpha_test.sv
// ----------------------------------------------------------------------------
// scaled_bitmap_blit_alpha_test
// Blitter front end: destination clipping, nearest-neighbor source scaling
// and alpha test for a scaled bitmap copy.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries command items (start, next pixel, fetched color word).
//   out_ch returns one result item per start, next or color item; command
//          code 3 is taken and dropped.
//   cfg_*  writes the rectangle registers; write only while the block is idle.
// Sequencing / throughput:
//   start and color pass through the queue into the output register and can
//   follow one per cycle while the output is free. A next item during a scan
//   runs through the pop, the multiply state, a 26-step restoring divider per
//   axis (both axes run side by side), the wait for the dividers and the emit
//   state. Items are executed one at a time by the back end.
// Stall behavior:
//   a two-entry command queue keeps accepting items while a result waits in
//   the output register; the back end stops when the output register is full
//   and in_ch.ready drops when the queue is full.
// Reset:
//   rst_n clears config, control, scan state and queue; no scan is active.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_bitmap_blit_alpha_test (
  input  wire                                 clk,
  input  wire                                 rst_n,
  sbba_in_if.sink                             in_ch,
  sbba_out_if.source                          out_ch,
  input  wire                                 cfg_we,
  input  wire [sbba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [sbba_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sbba_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  q_head_t head;
  logic    pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEST_LEFT:   cfg_nxt.dest_left   = cfg_data;
        REG_DEST_TOP:    cfg_nxt.dest_top    = cfg_data;
        REG_DEST_SPAN_X: cfg_nxt.dest_span_x = cfg_data[SPAN_W-1:0];
        REG_DEST_SPAN_Y: cfg_nxt.dest_span_y = cfg_data[SPAN_W-1:0];
        REG_SRC_LEFT:    cfg_nxt.src_left    = cfg_data[SPAN_W-1:0];
        REG_SRC_TOP:     cfg_nxt.src_top     = cfg_data[SPAN_W-1:0];
        REG_SRC_SPAN_X:  cfg_nxt.src_span_x  = cfg_data[SPAN_W-1:0];
        REG_SRC_SPAN_Y:  cfg_nxt.src_span_y  = cfg_data[SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sbba_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .pop_i  (pop),
    .head_o (head)
  );

  sbba_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg_r),
    .head_i (head),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/sbba_front.sv
// ----------------------------------------------------------------------------
// sbba_front
// Accepts command items, drops the unused code and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module sbba_front (
  input  wire                  clk,
  input  wire                  rst_n,
  sbba_in_if.sink              in_ch,
  input  wire                  pop_i,
  output sbba_pkg::q_head_t    head_o
);
  import sbba_pkg::*;

  typedef struct packed {
    cmd_t              cmd;
    logic [WORD_W-1:0] word;
  } q_entry_t;

  q_entry_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               keep;
  logic               push;
  logic               pop;

  // classify: only the three defined commands enter the queue
  always_comb begin
    case (cmd_t'(in_ch.command))
      CMD_START: keep = 1'b1;
      CMD_NEXT:  keep = 1'b1;
      CMD_COLOR: keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign pop         = pop_i && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{cmd: cmd_t'(in_ch.command), word: in_ch.pixel_word};
    end
  end

  assign head_o.valid = (cnt_r != '0);
  assign head_o.cmd   = mem_r[rd_ptr_r].cmd;
  assign head_o.word  = mem_r[rd_ptr_r].word;

endmodule

`default_nettype wire

>>> rtl/sbba_div.sv
// ----------------------------------------------------------------------------
// sbba_div
// Restoring divider, one quotient bit per cycle, for the source scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module sbba_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         go_i,
  input  wire [sbba_pkg::NUM_W-1:0]   num_i,
  input  wire [sbba_pkg::DEN_W-1:0]   den_i,
  output logic                        busy_o,
  output logic [sbba_pkg::NUM_W-1:0]  quo_o
);
  import sbba_pkg::*;

  logic [NUM_W-1:0]     nq_r, nq_nxt;     // numerator bits shift out, quotient bits in
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]       shifted;
  logic                 ge;

  assign shifted = {rem_r, nq_r[NUM_W-1]};
  assign ge      = (shifted >= {1'b0, den_r});

  always_comb begin
    nq_nxt  = nq_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (go_i) begin
      nq_nxt  = num_i;
      rem_nxt = '0;
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      nq_nxt  = {nq_r[NUM_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    if (go_i) begin
      den_r <= den_i;
    end
  end

  assign busy_o = (cnt_r != '0);
  assign quo_o  = nq_r;

endmodule

`default_nettype wire

>>> rtl/sbba_back.sv
// ----------------------------------------------------------------------------
// sbba_back
// Executes queued commands: clipping, scan stepping, scaling and alpha test,
// and holds the result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sbba_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sbba_pkg::cfg_t       cfg_i,
  input  sbba_pkg::q_head_t    head_i,
  output logic                 pop_o,
  sbba_out_if.source           out_ch
);
  import sbba_pkg::*;

  typedef struct packed {
    logic              empty;
    logic [DST_W-1:0]  min;
    logic [SRC_W-1:0]  len;
    logic [SRC_W-1:0]  skip;
  } axis_clip_t;

  function automatic axis_clip_t clip_axis(input logic [EDGE_W-1:0] edge_v,
                                           input logic [SPAN_W-1:0] span,
                                           input logic [14:0]       limit);
    axis_clip_t  r;
    logic signed [14:0] lo;
    logic signed [14:0] hi;
    logic signed [14:0] len;
    lo = $signed({{2{edge_v[EDGE_W-1]}}, edge_v});
    hi = lo + $signed({3'b000, span});
    r.skip = '0;
    if (lo < 0) begin
      r.skip = SRC_W'(-lo);
      lo     = '0;
    end
    if (hi > $signed(limit)) begin
      hi = $signed(limit);
    end
    len     = hi - lo;
    r.empty = (len <= 0);
    r.min   = lo[DST_W-1:0];
    r.len   = len[SRC_W-1:0];
    return r;
  endfunction

  back_state_t       state_r, state_nxt;
  logic [DST_W-1:0]  clip_min_x_r, clip_min_x_nxt;
  logic [DST_W-1:0]  clip_min_y_r, clip_min_y_nxt;
  logic [SRC_W-1:0]  clip_width_r, clip_width_nxt;
  logic [SRC_W-1:0]  clip_height_r, clip_height_nxt;
  logic [SRC_W-1:0]  skip_x_r, skip_x_nxt;
  logic [SRC_W-1:0]  skip_y_r, skip_y_nxt;
  logic [SRC_W-1:0]  scan_col_r, scan_col_nxt;
  logic [SRC_W-1:0]  scan_row_r, scan_row_nxt;
  logic [DST_W-1:0]  held_dst_x_r, held_dst_x_nxt;
  logic [DST_W-1:0]  held_dst_y_r, held_dst_y_nxt;
  logic              scanning_r, scanning_nxt;
  logic [SRC_W-1:0]  pos_x_r, pos_x_nxt;
  logic [SRC_W-1:0]  pos_y_r, pos_y_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  axis_clip_t        cx, cy;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [NUM_W-1:0]  num_x, num_y;
  logic [NUM_W-1:0]  quo_x, quo_y;
  logic              busy_x, busy_y;
  logic              div_go;
  logic [SRC_W-1:0]  q_x, q_y;
  logic [SRC_W-1:0]  col_inc, row_inc;
  logic              out_free;
  logic              commit;
  res_t              res;

  assign cx = clip_axis(cfg_i.dest_left, cfg_i.dest_span_x, 15'(FB_WIDTH));
  assign cy = clip_axis(cfg_i.dest_top,  cfg_i.dest_span_y, 15'(FB_HEIGHT));

  // numerators for round-half-up of span*pos/dspan
  assign prod_x = PROD_W'(cfg_i.src_span_x) * PROD_W'(pos_x_r);
  assign prod_y = PROD_W'(cfg_i.src_span_y) * PROD_W'(pos_y_r);
  assign num_x  = {prod_x, 1'b0} + NUM_W'(cfg_i.dest_span_x);
  assign num_y  = {prod_y, 1'b0} + NUM_W'(cfg_i.dest_span_y);

  sbba_div u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .go_i   (div_go),
    .num_i  (num_x),
    .den_i  ({cfg_i.dest_span_x, 1'b0}),
    .busy_o (busy_x),
    .quo_o  (quo_x)
  );

  sbba_div u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .go_i   (div_go),
    .num_i  (num_y),
    .den_i  ({cfg_i.dest_span_y, 1'b0}),
    .busy_o (busy_y),
    .quo_o  (quo_y)
  );

  // zero divisor gives a zero offset
  assign q_x     = (cfg_i.dest_span_x == '0) ? '0 : quo_x[SRC_W-1:0];
  assign q_y     = (cfg_i.dest_span_y == '0) ? '0 : quo_y[SRC_W-1:0];
  assign col_inc = scan_col_r + 1'b1;
  assign row_inc = scan_row_r + 1'b1;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt       = state_r;
    clip_min_x_nxt  = clip_min_x_r;
    clip_min_y_nxt  = clip_min_y_r;
    clip_width_nxt  = clip_width_r;
    clip_height_nxt = clip_height_r;
    skip_x_nxt      = skip_x_r;
    skip_y_nxt      = skip_y_r;
    scan_col_nxt    = scan_col_r;
    scan_row_nxt    = scan_row_r;
    held_dst_x_nxt  = held_dst_x_r;
    held_dst_y_nxt  = held_dst_y_r;
    scanning_nxt    = scanning_r;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    pop_o           = 1'b0;
    div_go          = 1'b0;
    commit          = 1'b0;
    res             = '0;

    case (state_r)
      ST_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          case (head_i.cmd)
            CMD_START: begin
              clip_min_x_nxt  = cx.min;
              clip_min_y_nxt  = cy.min;
              skip_x_nxt      = cx.skip;
              skip_y_nxt      = cy.skip;
              clip_width_nxt  = (cx.empty || cy.empty) ? '0 : cx.len;
              clip_height_nxt = (cx.empty || cy.empty) ? '0 : cy.len;
              scan_col_nxt    = '0;
              scan_row_nxt    = '0;
              scanning_nxt    = !(cx.empty || cy.empty);
              res.none_left   = cx.empty || cy.empty;
              commit          = 1'b1;
            end
            CMD_NEXT: begin
              if (scanning_r) begin
                pos_x_nxt = scan_col_r + skip_x_r;
                pos_y_nxt = scan_row_r + skip_y_r;
                state_nxt = ST_MUL;
              end else begin
                res.none_left = 1'b1;
                commit        = 1'b1;
              end
            end
            CMD_COLOR: begin
              res.out_dst_x    = held_dst_x_r;
              res.out_dst_y    = held_dst_y_r;
              res.write_enable = (head_i.word[ALPHA_LSB +: 8] > ALPHA_THRESH);
              res.out_word     = head_i.word;
              res.none_left    = !scanning_r;
              commit           = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        div_go    = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!busy_x && !busy_y) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          held_dst_x_nxt = clip_min_x_r + scan_col_r[DST_W-1:0];
          held_dst_y_nxt = clip_min_y_r + scan_row_r[DST_W-1:0];
          res.out_dst_x  = held_dst_x_nxt;
          res.out_dst_y  = held_dst_y_nxt;
          res.out_src_x  = SRC_W'(cfg_i.src_left) + q_x;
          res.out_src_y  = SRC_W'(cfg_i.src_top) + q_y;
          scan_col_nxt   = col_inc;
          if (col_inc >= clip_width_r) begin
            scan_col_nxt = '0;
            scan_row_nxt = row_inc;
            if (row_inc >= clip_height_r) begin
              scanning_nxt   = 1'b0;
              res.last_pixel = 1'b1;
            end
          end
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      clip_min_x_r  <= '0;
      clip_min_y_r  <= '0;
      clip_width_r  <= '0;
      clip_height_r <= '0;
      skip_x_r      <= '0;
      skip_y_r      <= '0;
      scan_col_r    <= '0;
      scan_row_r    <= '0;
      held_dst_x_r  <= '0;
      held_dst_y_r  <= '0;
      scanning_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clip_min_x_r  <= clip_min_x_nxt;
      clip_min_y_r  <= clip_min_y_nxt;
      clip_width_r  <= clip_width_nxt;
      clip_height_r <= clip_height_nxt;
      skip_x_r      <= skip_x_nxt;
      skip_y_r      <= skip_y_nxt;
      scan_col_r    <= scan_col_nxt;
      scan_row_r    <= scan_row_nxt;
      held_dst_x_r  <= held_dst_x_nxt;
      held_dst_y_r  <= held_dst_y_nxt;
      scanning_r    <= scanning_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r   <= pos_x_nxt;
    pos_y_r   <= pos_y_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_dst_x    = out_res_r.out_dst_x;
  assign out_ch.out_dst_y    = out_res_r.out_dst_y;
  assign out_ch.out_src_x    = out_res_r.out_src_x;
  assign out_ch.out_src_y    = out_res_r.out_src_y;
  assign out_ch.write_enable = out_res_r.write_enable;
  assign out_ch.out_word     = out_res_r.out_word;
  assign out_ch.last_pixel   = out_res_r.last_pixel;
  assign out_ch.none_left    = out_res_r.none_left;

  // scan position stays inside the clipped rectangle while scanning
  a_scan_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
    scanning_r |-> (scan_col_r < clip_width_r) && (scan_row_r < clip_height_r))
    else $error("scan position outside clipped rectangle");

  // both dividers start together right after the multiply cycle
  a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (state_r == ST_DIV) && busy_x && busy_y)
    else $error("dividers not running after multiply");

  // a next item only reaches the divider path during an active scan
  a_emit_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> scanning_r)
    else $error("pixel emitted with no active scan");

endmodule

`default_nettype wire
